[rtl/dfr_pkg.sv]
// Package for the sync/length/checksum deframer: status codes, state
// encodings and the records passed between the front, queue and back parts.
// No dependencies.
package dfr_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_PAYLOAD  = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_SUM  = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	// Frame parser states
	typedef enum logic [2:0] {
		F_HUNT,
		F_SYNC2,
		F_TYPE,
		F_LEN,
		F_PAYLOAD,
		F_CSUM
	} front_state_t;

	// Result sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_FETCH,
		B_SEND
	} back_state_t;

	// Register index decoded from paddr
	localparam logic REG_SYNC = 1'b0;

	localparam logic [7:0] SYNC_RESET = 8'h5A;

	// One frame outcome queued from front to back
	typedef struct packed {
		status_t    status;
		logic [7:0] ftype;
		logic [7:0] flen;
	} cmd_t;

	// Payload store write request from the front
	typedef struct packed {
		logic       we;
		logic [7:0] addr;
		logic [7:0] data;
	} store_wr_t;

endpackage

[rtl/dfr_if.sv]
// Valid/ready channel interfaces for the deframer: received bytes in,
// frame results out. Depends on nothing.
interface dfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] frame_type;
	logic [7:0] payload_length;
	logic [4:0] byte_index;
	logic [7:0] data_out;
	logic       last;

	modport source (output valid, output status, output frame_type, output payload_length,
		output byte_index, output data_out, output last, input ready);
	modport sink (input valid, input status, input frame_type, input payload_length,
		input byte_index, input data_out, input last, output ready);
endinterface

[rtl/dfr_front.sv]
// Deframer front part: accepts received bytes, tracks the frame layout and
// running sum, writes payload bytes and queues one command per finished frame.
// Depends on dfr_pkg and dfr_if.
module dfr_front #(
	parameter int MAX_FRAME_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	dfr_in_if.sink              rx,
	input  logic [7:0]          sync_byte,
	input  logic                q_full,
	output logic                push,
	output dfr_pkg::cmd_t       push_cmd,
	output dfr_pkg::store_wr_t  wr,
	input  logic                done
);

	dfr_pkg::front_state_t state_q, state_d;
	logic [7:0] sum_q;
	logic [7:0] type_q;
	logic [7:0] len_q;
	logic [7:0] cnt_q;
	logic       lock_q;

	logic       rdy;
	logic       acc;
	logic [7:0] b;
	logic       too_long;
	logic       cnt_end;

	assign b        = rx.rx_byte;
	assign too_long = (9'(b) + 9'd5) > 9'(MAX_FRAME_BYTES);
	assign cnt_end  = (9'(cnt_q) + 9'd1) == 9'(len_q);
	assign acc      = rx.valid && rdy;
	assign rx.ready = rdy;

	// Next state
	always_comb begin
		state_d = state_q;
		if (acc) begin
			unique case (state_q)
				dfr_pkg::F_HUNT: begin
					if (b == sync_byte) state_d = dfr_pkg::F_SYNC2;
				end
				dfr_pkg::F_SYNC2: begin
					state_d = (b == sync_byte) ? dfr_pkg::F_TYPE : dfr_pkg::F_HUNT;
				end
				dfr_pkg::F_TYPE: begin
					state_d = dfr_pkg::F_LEN;
				end
				dfr_pkg::F_LEN: begin
					if (too_long) state_d = dfr_pkg::F_HUNT;
					else if (b == 8'd0) state_d = dfr_pkg::F_CSUM;
					else state_d = dfr_pkg::F_PAYLOAD;
				end
				dfr_pkg::F_PAYLOAD: begin
					if (cnt_end) state_d = dfr_pkg::F_CSUM;
				end
				dfr_pkg::F_CSUM: begin
					state_d = dfr_pkg::F_HUNT;
				end
				default: state_d = dfr_pkg::F_HUNT;
			endcase
		end
	end

	// Outputs
	always_comb begin
		rdy      = 1'b1;
		push     = 1'b0;
		push_cmd = '{status: dfr_pkg::ST_PAYLOAD, ftype: type_q, flen: len_q};
		wr       = '{we: 1'b0, addr: cnt_q, data: b};
		unique case (state_q)
			dfr_pkg::F_LEN: begin
				rdy      = !q_full;
				push     = acc && too_long;
				push_cmd = '{status: dfr_pkg::ST_TOO_LONG, ftype: type_q, flen: b};
			end
			dfr_pkg::F_PAYLOAD: begin
				// hold payload bytes while the back still reads the last frame
				rdy   = !lock_q;
				wr.we = acc;
			end
			dfr_pkg::F_CSUM: begin
				rdy  = !q_full;
				push = acc;
				if (b != sum_q) push_cmd.status = dfr_pkg::ST_BAD_SUM;
				else if (len_q == 8'd0) push_cmd.status = dfr_pkg::ST_EMPTY;
				else push_cmd.status = dfr_pkg::ST_PAYLOAD;
			end
			default: begin
				rdy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfr_pkg::F_HUNT;
			sum_q   <= 8'd0;
			type_q  <= 8'd0;
			len_q   <= 8'd0;
			cnt_q   <= 8'd0;
			lock_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				case (state_q)
					dfr_pkg::F_HUNT: begin
						if (b == sync_byte) sum_q <= b;
					end
					dfr_pkg::F_SYNC2: begin
						sum_q <= sum_q + b;
					end
					dfr_pkg::F_TYPE: begin
						type_q <= b;
						sum_q  <= sum_q + b;
					end
					dfr_pkg::F_LEN: begin
						len_q <= b;
						sum_q <= sum_q + b;
						cnt_q <= 8'd0;
					end
					dfr_pkg::F_PAYLOAD: begin
						sum_q <= sum_q + b;
						cnt_q <= cnt_q + 8'd1;
					end
					default: begin
						sum_q <= sum_q;
					end
				endcase
			end
			if (push && push_cmd.status == dfr_pkg::ST_PAYLOAD) lock_q <= 1'b1;
			else if (done) lock_q <= 1'b0;
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("front pushed into a full queue");

	a_no_write_locked: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> !lock_q)
		else $error("payload store written while back still reads it");

	a_lock_set: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_cmd.status == dfr_pkg::ST_PAYLOAD) |=> lock_q)
		else $error("store lock not taken after good frame");

endmodule

[rtl/dfr_queue.sv]
// Two-entry command queue between the deframer front and back parts.
// Depends on dfr_pkg.
module dfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dfr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output dfr_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	dfr_pkg::cmd_t     mem_q [DEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [PW:0]       cnt_q;

	assign full  = cnt_q == (PW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + PW'(1);
			if (pop) rptr_q <= rptr_q + PW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/dfr_back.sv]
// Deframer back part: takes frame commands from the queue, holds the payload
// store and delivers results through a registered output stage.
// Depends on dfr_pkg and dfr_if.
module dfr_back #(
	parameter int MAX_FRAME_BYTES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dfr_pkg::cmd_t      head,
	input  logic               q_empty,
	output logic               pop,
	input  dfr_pkg::store_wr_t wr,
	output logic               done,
	dfr_out_if.source          res
);

	localparam int STORE_DEPTH = (MAX_FRAME_BYTES > 5) ? MAX_FRAME_BYTES - 5 : 1;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [7:0] store_q [STORE_DEPTH];

	dfr_pkg::back_state_t state_q, state_d;
	dfr_pkg::cmd_t        cmd_q;
	logic [7:0]           idx_q;
	logic [7:0]           rd_s1;

	logic                 out_valid_q;
	dfr_pkg::status_t     status_q;
	logic [7:0]           type_q;
	logic [7:0]           len_q;
	logic [4:0]           index_q;
	logic [7:0]           data_q;
	logic                 last_q;

	logic                 slot_free;
	logic                 load;
	dfr_pkg::status_t     ld_status;
	logic [7:0]           ld_type;
	logic [7:0]           ld_len;
	logic [4:0]           ld_index;
	logic [7:0]           ld_data;
	logic                 ld_last;
	logic                 idx_end;

	assign slot_free = !out_valid_q || res.ready;
	assign idx_end   = (9'(idx_q) + 9'd1) == 9'(cmd_q.flen);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dfr_pkg::B_IDLE: begin
				if (pop && head.status == dfr_pkg::ST_PAYLOAD) state_d = dfr_pkg::B_FETCH;
			end
			dfr_pkg::B_FETCH: begin
				state_d = dfr_pkg::B_SEND;
			end
			dfr_pkg::B_SEND: begin
				if (slot_free) state_d = idx_end ? dfr_pkg::B_IDLE : dfr_pkg::B_FETCH;
			end
			default: state_d = dfr_pkg::B_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		done      = 1'b0;
		ld_status = head.status;
		ld_type   = head.ftype;
		ld_len    = head.flen;
		ld_index  = 5'd0;
		ld_data   = 8'd0;
		ld_last   = 1'b1;
		unique case (state_q)
			dfr_pkg::B_IDLE: begin
				pop  = !q_empty && slot_free;
				load = pop && head.status != dfr_pkg::ST_PAYLOAD;
			end
			dfr_pkg::B_SEND: begin
				load      = slot_free;
				done      = slot_free && idx_end;
				ld_status = dfr_pkg::ST_PAYLOAD;
				ld_type   = cmd_q.ftype;
				ld_len    = cmd_q.flen;
				ld_index  = idx_q[4:0];
				ld_data   = rd_s1;
				ld_last   = idx_end;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Payload store: front writes; back reads the next address only after the previous byte is sent
	always_ff @(posedge clk) begin
		if (wr.we) store_q[wr.addr[AW-1:0]] <= wr.data;
		if (state_q == dfr_pkg::B_FETCH) rd_s1 <= store_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head;
		if (load) begin
			status_q <= ld_status;
			type_q   <= ld_type;
			len_q    <= ld_len;
			index_q  <= ld_index;
			data_q   <= ld_data;
			last_q   <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfr_pkg::B_IDLE;
			idx_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) idx_q <= 8'd0;
			else if (load && state_q == dfr_pkg::B_SEND && !idx_end) idx_q <= idx_q + 8'd1;
			if (load) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.status         = status_q;
	assign res.frame_type     = type_q;
	assign res.payload_length = len_q;
	assign res.byte_index     = index_q;
	assign res.data_out       = data_q;
	assign res.last           = last_q;

	a_fetch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dfr_pkg::B_FETCH |-> idx_q < cmd_q.flen)
		else $error("payload read past frame length");

	a_send_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfr_pkg::B_SEND && $past(state_q) != dfr_pkg::B_SEND)
		|-> $past(state_q) == dfr_pkg::B_FETCH)
		else $error("send entered without a store read");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (out_valid_q && last_q && status_q == dfr_pkg::ST_PAYLOAD))
		else $error("store released without last payload result");

endmodule

[rtl/sync_length_checksum_deframer.sv]
// Sync/length/checksum frame receiver. A frame outcome passes from the front
// through the command queue to the output register, and payload results leave
// one at a time, each after a registered read of the payload store. Payload
// bytes of a next frame wait while the store is still being read out. Reset
// clears all control state and loads sync_byte with 0x5A; the payload store is
// not cleared.
module sync_length_checksum_deframer #(
	parameter int MAX_FRAME_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	dfr_in_if.sink      rx,
	dfr_out_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]         sync_q;
	logic               reg_idx;
	logic               q_full;
	logic               q_empty;
	logic               push;
	logic               pop;
	logic               done;
	dfr_pkg::cmd_t      push_cmd;
	dfr_pkg::cmd_t      head;
	dfr_pkg::store_wr_t wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign prdata  = (reg_idx == dfr_pkg::REG_SYNC) ? {24'd0, sync_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= dfr_pkg::SYNC_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == dfr_pkg::REG_SYNC) begin
			sync_q <= pwdata[7:0];
		end
	end

	dfr_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.sync_byte(sync_q),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd),
		.wr       (wr),
		.done     (done)
	);

	dfr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	dfr_back #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_empty(q_empty),
		.pop    (pop),
		.wr     (wr),
		.done   (done),
		.res    (res)
	);

endmodule
